@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define GGQM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked from the first edge, reset included
`define GGQM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ggqm_pkg.sv @@
// ----------------------------------------------------------------------------
// ggqm_pkg
// types, constants and helpers of the greedy quad mesher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ggqm_pkg;

	localparam int GRID_SIDE = 64;
	localparam int IDX_W     = $clog2(GRID_SIDE);
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int CNT_W     = $clog2(GRID_SIDE + 1);
	localparam int RUN_W     = 7;
	localparam int FRAC_BITS = 16;
	localparam int TS_W      = 31;
	localparam int MUL_N_W   = 8;
	localparam int PROD_W    = TS_W + MUL_N_W;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic [TS_W-1:0] TILE_RESET = TS_W'(1) << FRAC_BITS;
	localparam logic [5:0]      SIDE_RESET = 6'd32;

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

	typedef enum logic [2:0] {
		REG_TILE_X    = 3'd0,
		REG_TILE_Y    = 3'd1,
		REG_TILE_Z    = 3'd2,
		REG_MARGIN    = 3'd3,
		REG_ORIGIN_X  = 3'd4,
		REG_ORIGIN_Y  = 3'd5,
		REG_SIDE_MASK = 3'd6
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_QUAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_TRI    = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BUILD_RD,
		ST_BUILD_WR,
		ST_STATUS,
		ST_SCAN,
		ST_SCAN_D,
		ST_SCAN_N,
		ST_CLEAR,
		ST_CORNER_M,
		ST_CORNER_A,
		ST_EMIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] cell_x;
		logic [IDX_W-1:0] cell_y;
		logic             cell_filled;
		logic             last_cell;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               tri_needed;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [TS_W-1:0]    tile_size_x;
		logic [TS_W-1:0]    tile_size_y;
		logic [TS_W-1:0]    tile_size_z;
		logic [TS_W-1:0]    margin;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [5:0]         side_mask;
	} cfg_t;

	// box corner codes: bit0 x high, bit1 y high, bit2 z high
	localparam logic [2:0] SIDE_TRIS [6][6] = '{
		'{3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2},
		'{3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5},
		'{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
		'{3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3},
		'{3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1},
		'{3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6}
	};

	function automatic logic [2:0] side_corner(logic [2:0] s, logic t, logic [1:0] k);
		logic [2:0] pos;
		pos = t ? (3'd3 + {1'b0, k}) : {1'b0, k};
		return SIDE_TRIS[s][pos];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > SAT_MAX) c = SAT_MAX;
		else if (v < SAT_MIN) c = SAT_MIN;
		return c[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/ggqm_ram.sv @@
// ----------------------------------------------------------------------------
// ggqm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ggqm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/ggqm_cfg.sv @@
// ----------------------------------------------------------------------------
// ggqm_cfg
// apb register file for tile sizes, margin, origin and side mask
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ggqm_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output ggqm_pkg::cfg_t     cfg
);
	import ggqm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_size_x <= TILE_RESET;
			cfg_q.tile_size_y <= TILE_RESET;
			cfg_q.tile_size_z <= TILE_RESET;
			cfg_q.margin      <= '0;
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.side_mask   <= SIDE_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_TILE_X:    cfg_q.tile_size_x <= pwdata[TS_W-1:0];
				REG_TILE_Y:    cfg_q.tile_size_y <= pwdata[TS_W-1:0];
				REG_TILE_Z:    cfg_q.tile_size_z <= pwdata[TS_W-1:0];
				REG_MARGIN:    cfg_q.margin      <= pwdata[TS_W-1:0];
				REG_ORIGIN_X:  cfg_q.origin_x    <= pwdata;
				REG_ORIGIN_Y:  cfg_q.origin_y    <= pwdata;
				REG_SIDE_MASK: cfg_q.side_mask   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TILE_X:    prdata = {1'b0, cfg_q.tile_size_x};
			REG_TILE_Y:    prdata = {1'b0, cfg_q.tile_size_y};
			REG_TILE_Z:    prdata = {1'b0, cfg_q.tile_size_z};
			REG_MARGIN:    prdata = {1'b0, cfg_q.margin};
			REG_ORIGIN_X:  prdata = cfg_q.origin_x;
			REG_ORIGIN_Y:  prdata = cfg_q.origin_y;
			REG_SIDE_MASK: prdata = {26'd0, cfg_q.side_mask};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/grid_greedy_quad_mesher.sv @@
// a plain cell load is taken in ST_IDLE with no beat; the last cell adds a run-length
// rebuild through ST_BUILD_RD and ST_BUILD_WR for each grid cell, then one status beat
// a quad request passes ST_SCAN and ST_SCAN_D per scanned cell, ST_SCAN_N where the run
// goes on and ST_SCAN per row end, ST_CLEAR per cleared cell and row, ST_CORNER_M and
// ST_CORNER_A per corner product, ST_EMIT per side and beat; one request in flight at a time
// reset clears control state only; the grid memories stay undefined until loaded
// ----------------------------------------------------------------------------
// grid_greedy_quad_mesher
// greedy rectangle mesher over an occupancy grid held in on-chip ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module grid_greedy_quad_mesher (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire ggqm_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output ggqm_pkg::res_t     res,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready
);
	import ggqm_pkg::*;

	cfg_t cfg;

	ggqm_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// memories
	logic                   occ_we, occ_rd;
	logic [2*IDX_W-1:0]     occ_waddr, occ_raddr;
	logic                   run_we;
	logic [2*IDX_W-1:0]     run_waddr, run_raddr;
	logic [RUN_W-1:0]       run_wdata, run_rd;

	ggqm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
		.clk, .we(occ_we), .waddr(occ_waddr), .wdata(cmd.cell_filled),
		.raddr(occ_raddr), .rdata(occ_rd)
	);

	ggqm_ram #(.WIDTH(RUN_W), .DEPTH(CELLS)) u_run (
		.clk, .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
		.raddr(run_raddr), .rdata(run_rd)
	);

	state_t state_q, state_d;
	logic [CNT_W-1:0]   rows_q, rows_d, cols_q, cols_d;
	logic [CNT_W-1:0]   row_q, row_d, col_q, col_d, start_q, start_d;
	logic [RUN_W-1:0]   width_q, width_d;
	logic               wv_q, wv_d, any_empty_q, any_empty_d;
	logic [IDX_W-1:0]   bx_q, bx_d, by_q, by_d;
	logic [MUL_N_W-1:0] qx0_q, qx0_d, qx1_q, qx1_d, qy0_q, qy0_d, qy1_q, qy1_d;
	logic [MUL_N_W-1:0] clr_x_q, clr_x_d, clr_y_q, clr_y_d;
	logic [2:0]         k_q, k_d, s_q, s_d;
	logic               t_q, t_d;
	logic [PROD_W-1:0]  prod_q, prod_d;
	logic signed [31:0] cx0_q, cx1_q, cy0_q, cy1_q, cz0_q, cz1_q;
	logic signed [31:0] corner;
	logic               corner_we;
	res_t               res_q, res_d;
	logic               res_valid_q, res_load, out_free, accept;

	// corner arithmetic
	logic [MUL_N_W-1:0]      mul_n;
	logic [TS_W-1:0]         mul_ts;
	logic signed [SUM_W-1:0] add_m, add_o, sum;
	logic [CNT_W-1:0]        col_nx;
	logic [RUN_W-1:0]        wsel;
	logic [5:0]              mask_above;
	logic [2:0]              ca, cb, cc;

	assign accept    = cmd_valid & ~cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_free  = ~res_valid_q | ~res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign occ_we    = accept & (op_t'(cmd.operation) == OP_LOAD);
	assign occ_waddr = {cmd.cell_x, cmd.cell_y};
	assign occ_raddr = {bx_q, by_q};
	assign col_nx    = col_q + CNT_W'(1);

	always_comb begin
		unique case (k_q)
			3'd0:    begin mul_n = qx0_q;       mul_ts = cfg.tile_size_x; end
			3'd1:    begin mul_n = qx1_q;       mul_ts = cfg.tile_size_x; end
			3'd2:    begin mul_n = qy0_q;       mul_ts = cfg.tile_size_y; end
			3'd3:    begin mul_n = qy1_q;       mul_ts = cfg.tile_size_y; end
			3'd5:    begin mul_n = MUL_N_W'(1); mul_ts = cfg.tile_size_z; end
			default: begin mul_n = '0;          mul_ts = cfg.tile_size_z; end
		endcase
	end

	always_comb begin
		add_m = $signed({{(SUM_W-TS_W){1'b0}}, cfg.margin});
		if (k_q[0]) add_m = -add_m;
		if (k_q < 3'd2)      add_o = SUM_W'(cfg.origin_x);
		else if (k_q < 3'd4) add_o = SUM_W'(cfg.origin_y);
		else                 add_o = '0;
		sum    = $signed({2'b00, prod_q}) + add_m + add_o;
		corner = sat32(sum);
	end

	assign mask_above = cfg.side_mask >> ({1'b0, s_q} + 4'd1);
	assign ca = side_corner(s_q, t_q, 2'd0);
	assign cb = side_corner(s_q, t_q, 2'd1);
	assign cc = side_corner(s_q, t_q, 2'd2);

	always_comb begin
		state_d     = state_q;
		rows_d      = rows_q;
		cols_d      = cols_q;
		row_d       = row_q;
		col_d       = col_q;
		start_d     = start_q;
		width_d     = width_q;
		wv_d        = wv_q;
		any_empty_d = any_empty_q;
		bx_d        = bx_q;
		by_d        = by_q;
		qx0_d       = qx0_q;
		qx1_d       = qx1_q;
		qy0_d       = qy0_q;
		qy1_d       = qy1_q;
		clr_x_d     = clr_x_q;
		clr_y_d     = clr_y_q;
		k_d         = k_q;
		s_d         = s_q;
		t_d         = t_q;
		prod_d      = prod_q;
		corner_we   = 1'b0;
		run_we      = 1'b0;
		run_waddr   = {bx_q, by_q};
		run_wdata   = '0;
		run_raddr   = {row_q[IDX_W-1:0], col_q[IDX_W-1:0]};
		res_load    = 1'b0;
		res_d       = '0;
		wsel        = wv_q ? width_q : run_rd;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(cmd.operation) == OP_QUAD) begin
						state_d = ST_SCAN;
					end else if (cmd.last_cell) begin
						rows_d      = {1'b0, cmd.cell_x} + CNT_W'(1);
						cols_d      = {1'b0, cmd.cell_y} + CNT_W'(1);
						bx_d        = cmd.cell_x;
						by_d        = '0;
						any_empty_d = 1'b0;
						row_d       = '0;
						col_d       = '0;
						start_d     = '0;
						width_d     = '0;
						wv_d        = 1'b0;
						state_d     = ST_BUILD_RD;
					end
				end
			end
			ST_BUILD_RD: begin
				// run length of the row below; unused on the far row
				run_raddr = {bx_q + IDX_W'(1), by_q};
				state_d   = ST_BUILD_WR;
			end
			ST_BUILD_WR: begin
				run_we = 1'b1;
				if (!occ_rd) begin
					any_empty_d = 1'b1;
					run_wdata   = '0;
				end else if ({1'b0, bx_q} == rows_q - CNT_W'(1)) begin
					run_wdata = RUN_W'(1);
				end else begin
					run_wdata = run_rd + RUN_W'(1);
				end
				state_d = ST_BUILD_RD;
				if ({1'b0, by_q} + CNT_W'(1) < cols_q) begin
					by_d = by_q + IDX_W'(1);
				end else begin
					by_d = '0;
					if (bx_q == '0) state_d = ST_STATUS;
					else            bx_d = bx_q - IDX_W'(1);
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					res_load         = 1'b1;
					res_d.kind       = KIND_STATUS;
					res_d.tri_needed = any_empty_q;
					res_d.last       = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (row_q >= rows_q) begin
					state_d = ST_DONE;
				end else if (col_q >= cols_q) begin
					row_d   = row_q + CNT_W'(1);
					col_d   = '0;
					start_d = '0;
					wv_d    = 1'b0;
				end else begin
					state_d = ST_SCAN_D;
				end
			end
			ST_SCAN_D: begin
				if (run_rd == '0) begin
					start_d = col_nx;
					wv_d    = 1'b0;
					col_d   = col_nx;
					state_d = ST_SCAN;
				end else begin
					width_d = wsel;
					wv_d    = 1'b1;
					if (col_nx >= cols_q) begin
						qx0_d   = {1'b0, row_q};
						qx1_d   = {1'b0, row_q} + {1'b0, wsel};
						qy0_d   = {1'b0, start_q};
						qy1_d   = {1'b0, col_nx};
						clr_x_d = {1'b0, row_q};
						clr_y_d = {1'b0, start_q};
						start_d = col_nx;
						wv_d    = 1'b0;
						col_d   = col_nx;
						state_d = ST_CLEAR;
					end else begin
						run_raddr = {row_q[IDX_W-1:0], col_nx[IDX_W-1:0]};
						state_d   = ST_SCAN_N;
					end
				end
			end
			ST_SCAN_N: begin
				col_d = col_nx;
				if (run_rd != width_q) begin
					qx0_d   = {1'b0, row_q};
					qx1_d   = {1'b0, row_q} + {1'b0, width_q};
					qy0_d   = {1'b0, start_q};
					qy1_d   = {1'b0, col_nx};
					clr_x_d = {1'b0, row_q};
					clr_y_d = {1'b0, start_q};
					start_d = col_nx;
					wv_d    = 1'b0;
					state_d = ST_CLEAR;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_CLEAR: begin
				if (clr_x_q < qx1_q && clr_x_q < {1'b0, rows_q}) begin
					if (clr_y_q < qy1_q) begin
						run_we    = 1'b1;
						run_waddr = {clr_x_q[IDX_W-1:0], clr_y_q[IDX_W-1:0]};
						clr_y_d   = clr_y_q + MUL_N_W'(1);
					end else begin
						clr_x_d = clr_x_q + MUL_N_W'(1);
						clr_y_d = qy0_q;
					end
				end else begin
					k_d     = '0;
					state_d = ST_CORNER_M;
				end
			end
			ST_CORNER_M: begin
				prod_d  = mul_n * mul_ts;
				state_d = ST_CORNER_A;
			end
			ST_CORNER_A: begin
				corner_we = 1'b1;
				if (k_q == 3'd5) begin
					s_d     = '0;
					t_d     = 1'b0;
					state_d = ST_EMIT;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = ST_CORNER_M;
				end
			end
			ST_EMIT: begin
				if (cfg.side_mask == '0) begin
					if (out_free) begin
						res_load   = 1'b1;
						res_d.kind = KIND_EMPTY;
						res_d.last = 1'b1;
						state_d    = ST_IDLE;
					end
				end else if (!cfg.side_mask[s_q]) begin
					s_d = s_q + 3'd1;
				end else if (out_free) begin
					res_load   = 1'b1;
					res_d.kind = KIND_TRI;
					res_d.a_x  = ca[0] ? cx1_q : cx0_q;
					res_d.a_y  = ca[1] ? cy1_q : cy0_q;
					res_d.a_z  = ca[2] ? cz1_q : cz0_q;
					res_d.b_x  = cb[0] ? cx1_q : cx0_q;
					res_d.b_y  = cb[1] ? cy1_q : cy0_q;
					res_d.b_z  = cb[2] ? cz1_q : cz0_q;
					res_d.c_x  = cc[0] ? cx1_q : cx0_q;
					res_d.c_y  = cc[1] ? cy1_q : cy0_q;
					res_d.c_z  = cc[2] ? cz1_q : cz0_q;
					res_d.last = t_q & (mask_above == '0);
					if (res_d.last) state_d = ST_IDLE;
					if (t_q) begin
						t_d = 1'b0;
						s_d = s_q + 3'd1;
					end else begin
						t_d = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_d.kind = KIND_DONE;
					res_d.last = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= '0;
			cols_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			start_q     <= '0;
			width_q     <= '0;
			wv_q        <= 1'b0;
			any_empty_q <= 1'b0;
			bx_q        <= '0;
			by_q        <= '0;
			clr_x_q     <= '0;
			clr_y_q     <= '0;
			k_q         <= '0;
			s_q         <= '0;
			t_q         <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rows_q      <= rows_d;
			cols_q      <= cols_d;
			row_q       <= row_d;
			col_q       <= col_d;
			start_q     <= start_d;
			width_q     <= width_d;
			wv_q        <= wv_d;
			any_empty_q <= any_empty_d;
			bx_q        <= bx_d;
			by_q        <= by_d;
			clr_x_q     <= clr_x_d;
			clr_y_q     <= clr_y_d;
			k_q         <= k_d;
			s_q         <= s_d;
			t_q         <= t_d;
			if (res_load)        res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		qx0_q  <= qx0_d;
		qx1_q  <= qx1_d;
		qy0_q  <= qy0_d;
		qy1_q  <= qy1_d;
		prod_q <= prod_d;
		if (res_load) res_q <= res_d;
		if (corner_we) begin
			case (k_q)
				3'd0:    cx0_q <= corner;
				3'd1:    cx1_q <= corner;
				3'd2:    cy0_q <= corner;
				3'd3:    cy1_q <= corner;
				3'd4:    cz0_q <= corner;
				default: cz1_q <= corner;
			endcase
		end
	end

	`GGQM_ASSERT(a_run_we_src, clk, arst_n, run_we |-> (state_q == ST_BUILD_WR || state_q == ST_CLEAR), "run memory written outside build or clear")
	`GGQM_ASSERT(a_clear_in_grid, clk, arst_n, (state_q == ST_CLEAR && run_we) |-> (clr_x_q < {1'b0, rows_q} && clr_y_q < {1'b0, cols_q}), "clear beyond grid size")
	`GGQM_ASSERT(a_last_ends, clk, arst_n, (res_load && res_d.last) |=> state_q == ST_IDLE, "final beat did not end the request")
	`GGQM_ASSERT(a_no_overwrite, clk, arst_n, res_load |-> out_free, "result register overwritten while held")
	`GGQM_ASSERT_ALWAYS(a_status_only, clk, (res_valid && res.kind != KIND_STATUS) |-> !res.tri_needed, "tri_needed set off a status beat")

endmodule

`default_nettype wire
